[sv/fcrc_pkg.sv]
package fcrc_pkg;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_TOP       = 16'h8000;
    localparam logic [3:0]  FIRST_COVERED = 4'd7;
    localparam logic [3:0]  SHORT_LIMIT   = 4'd6;
    localparam logic [3:0]  POS_SAT       = 4'd8;

    // result queue geometry; one item can push up to three results
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_PUSH    = 3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_SHORT    = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       mode;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
    } out_item_t;

    // results handed from the compute stage to the queue
    typedef struct packed {
        logic [1:0]                 cnt;
        out_item_t [MAX_PUSH-1:0]   items;
    } push_t;

    // augmented crc step: table(high byte) ^ (crc << 8) ^ byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic [15:0] t;
        acc = '0;
        t   = {crc[15:8], 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (((t ^ acc) & CRC_TOP) != 16'h0000)
                acc = {acc[14:0], 1'b0} ^ CRC_POLY;
            else
                acc = {acc[14:0], 1'b0};
            t = {t[14:0], 1'b0};
        end
        return acc ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    endfunction

endpackage

[sv/fcrc_proc.sv]
module fcrc_proc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  fcrc_pkg::in_item_t byte_item,
    input  logic              room,
    output fcrc_pkg::push_t   push
);
    import fcrc_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    in_item_t    s1_item_reg;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held1_reg;
    logic [3:0]  pos_reg, pos_next;
    logic        mode_reg, mode_next;

    logic        advance;
    logic        md;
    logic        emit_old;
    logic [15:0] crc_a;
    logic [7:0]  prev;
    logic [7:0]  lo, hi;
    logic        bad;
    out_item_t   t0, t1;
    logic [1:0]  tn;

    assign advance       = s1_valid_reg && room;
    assign byte_stall    = s1_valid_reg && !room;
    assign s1_valid_next = byte_valid || byte_stall;

    always_comb
    begin
        md       = (pos_reg == 4'd0) ? s1_item_reg.mode : mode_reg;
        mode_next = md;
        emit_old = (pos_reg >= 4'd2);
        crc_a    = (pos_reg >= FIRST_COVERED) ? crc_fold(crc_reg, held0_reg) : crc_reg;
        prev     = held1_reg;
        lo       = crc_a[7:0];
        hi       = crc_a[15:8];
        bad      = (prev != lo) || (s1_item_reg.data_byte != hi);

        // tail results of a frame's final item
        t0 = '0;
        t1 = '0;
        tn = 2'd0;
        if (s1_item_reg.last_byte)
        begin
            if (pos_reg <= SHORT_LIMIT)
            begin
                if (pos_reg >= 4'd1)
                begin
                    t0 = '{out_byte: prev, out_last: 1'b0, status: STATUS_OK};
                    t1 = '{out_byte: s1_item_reg.data_byte, out_last: 1'b1,
                           status: STATUS_SHORT};
                    tn = 2'd2;
                end
                else
                begin
                    t0 = '{out_byte: s1_item_reg.data_byte, out_last: 1'b1,
                           status: STATUS_SHORT};
                    tn = 2'd1;
                end
            end
            else if (md)
            begin
                t0 = '{out_byte: lo, out_last: 1'b0, status: STATUS_OK};
                t1 = '{out_byte: hi, out_last: 1'b1, status: STATUS_OK};
                tn = 2'd2;
            end
            else
            begin
                t0 = '{out_byte: prev, out_last: 1'b0, status: STATUS_OK};
                t1 = '{out_byte: s1_item_reg.data_byte, out_last: 1'b1,
                       status: bad ? STATUS_MISMATCH : STATUS_OK};
                tn = 2'd2;
            end
        end

        push = '0;
        if (advance)
        begin
            if (emit_old)
            begin
                push.items[0] = '{out_byte: held0_reg, out_last: 1'b0, status: STATUS_OK};
                push.items[1] = t0;
                push.items[2] = t1;
                push.cnt      = tn + 2'd1;
            end
            else
            begin
                push.items[0] = t0;
                push.items[1] = t1;
                push.cnt      = tn;
            end
        end

        if (s1_item_reg.last_byte)
        begin
            crc_next = '0;
            pos_next = '0;
        end
        else
        begin
            crc_next = crc_a;
            pos_next = (pos_reg < POS_SAT) ? pos_reg + 4'd1 : pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            crc_reg      <= '0;
            held0_reg    <= '0;
            held1_reg    <= '0;
            pos_reg      <= '0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                crc_reg   <= crc_next;
                held0_reg <= held1_reg;
                held1_reg <= s1_item_reg.data_byte;
                pos_reg   <= pos_next;
                mode_reg  <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall)
            s1_item_reg <= byte_item;
    end

    // the frame counter restarts after every final item
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.last_byte |=> pos_reg == 4'd0)
        else $error("byte position not cleared at frame end");

    // a frame position never exceeds the saturation point
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_SAT)
        else $error("byte position out of range");

    // a waiting item stays in the input register while the input is stalled
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |=> $stable(s1_item_reg))
        else $error("held item changed under stall");

endmodule

[sv/fcrc_queue.sv]
module fcrc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  fcrc_pkg::push_t    push,
    output logic               room,
    output logic               res_valid,
    input  logic               res_stall,
    output fcrc_pkg::out_item_t res_item
);
    import fcrc_pkg::*;

    out_item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;

    assign res_valid = (count_reg != '0);
    assign res_item  = mem_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;
    // room for a full burst of results regardless of this cycle's pop
    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_PUSH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PUSH; k++)
        begin
            if (2'(k) < push.cnt)
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push.items[k];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("results pushed without room");

    // a stalled result stays offered and unchanged
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result changed");

endmodule

[sv/frame_crc16_check_insert_top.sv]
// flow: an accepted item is captured in the input register at its accepting edge and
// its results go to the result queue when it advances with room there; a data byte
// waits in the holding registers until two later items or the frame's end push it
// throughput: one item per cycle sustained; the input stalls only while the eight-entry
// result queue holds more than five results, room for the three of a final item
// reset: rst_n asynchronous active low clears crc, byte position, mode and queue
module frame_crc16_check_insert_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  fcrc_pkg::in_item_t  byte_item,
    output logic                res_valid,
    input  logic                res_stall,
    output fcrc_pkg::out_item_t res_item
);
    import fcrc_pkg::*;

    push_t push;
    logic  room;

    fcrc_proc u_proc (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .room       (room),
        .push       (push)
    );

    fcrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
